### design/ohc_pkg.sv
// shared types, constants and helpers of the object record to hex converter
`timescale 1ns / 1ps

package ohc_pkg;

    // reset value of the largest data byte count per hex record
    localparam logic [7:0] MaxRecordReset = 8'd16;

    // default depth of the command queue between front and back
    localparam int QueueDepth = 2;

    // character codes
    localparam logic [7:0] CharColon   = 8'h3A;
    localparam logic [7:0] CharZero    = 8'h30;
    localparam logic [7:0] CharNewline = 8'h0A;
    localparam logic [7:0] CharError   = 8'h00;

    // one command from the parser to the text sequencer
    typedef struct packed {
        logic       is_err;
        logic       is_done;
        logic       has_hdr;
        logic       has_data;
        logic       has_tail;
        logic       rtype;
        logic [7:0] len;
        logic [7:0] addr_hi;
        logic [7:0] addr_lo;
        logic [7:0] data;
        logic [7:0] csum;
    } t_cmd;

    // uppercase ascii hex digit of a nibble
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < 4'd10) begin
            ch = CharZero + {4'h0, nib};
        end else begin
            ch = 8'h37 + {4'h0, nib};
        end
        return ch;
    endfunction

endpackage

### design/ohc_front.sv
// record parser: accepts object bytes and turns them into text commands
`timescale 1ns / 1ps

module ohc_front
    import ohc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_in_byte,
    output logic       o_stall,
    input  logic [7:0] i_max_rec,
    input  logic       i_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    // parse phases
    localparam logic [3:0] PhType   = 4'd0;
    localparam logic [3:0] PhLenLo  = 4'd1;
    localparam logic [3:0] PhLenHi  = 4'd2;
    localparam logic [3:0] PhSkip   = 4'd3;
    localparam logic [3:0] PhEndA   = 4'd4;
    localparam logic [3:0] PhEndB   = 4'd5;
    localparam logic [3:0] PhEndLo  = 4'd6;
    localparam logic [3:0] PhEndHi  = 4'd7;
    localparam logic [3:0] PhSeg    = 4'd8;
    localparam logic [3:0] PhAddrLo = 4'd9;
    localparam logic [3:0] PhAddrHi = 4'd10;
    localparam logic [3:0] PhData   = 4'd11;
    localparam logic [3:0] PhCrc    = 4'd12;

    // record kinds
    localparam logic [1:0] KindSkip    = 2'd0;
    localparam logic [1:0] KindContent = 2'd1;
    localparam logic [1:0] KindEnd     = 2'd2;

    // record type bytes
    localparam logic [7:0] TypeEnd     = 8'h04;
    localparam logic [7:0] TypeContent = 8'h06;
    localparam logic [7:0] TypeLimit   = 8'h22;

    logic [3:0]  r_phase, n_phase;
    logic [1:0]  r_kind, n_kind;
    logic [15:0] r_bytes_left, n_bytes_left;
    logic [15:0] r_addr, n_addr;
    logic [7:0]  r_chunk, n_chunk;
    logic [7:0]  r_sum, n_sum;
    logic        r_halted, n_halted;

    logic        accept;
    logic        work;
    logic        fail;
    logic [15:0] full_len;
    logic [7:0]  lim;
    logic [7:0]  len;
    logic        chunk_open;
    logic [7:0]  sum_base;
    logic [7:0]  new_sum;
    logic [7:0]  new_chunk;
    logic [7:0]  end_sum;

    // the queue sets the pace of the parser
    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    assign work    = accept && !r_halted;

    // hex record sizing for the data phase
    assign full_len   = {i_in_byte, r_bytes_left[7:0]};
    assign lim        = (i_max_rec == 8'd0) ? 8'd1 : i_max_rec;
    assign len        = (r_bytes_left < {8'h00, lim}) ? r_bytes_left[7:0] : lim;
    assign chunk_open = (r_chunk == 8'd0);
    assign sum_base   = chunk_open ? (len + r_addr[15:8] + r_addr[7:0]) : r_sum;
    assign new_sum    = sum_base + i_in_byte;
    assign new_chunk  = (chunk_open ? len : r_chunk) - 8'd1;
    assign end_sum    = r_addr[7:0] + i_in_byte + 8'd1;

    // phase decoder and command build
    always_comb begin
        n_phase      = r_phase;
        n_kind       = r_kind;
        n_bytes_left = r_bytes_left;
        n_addr       = r_addr;
        n_chunk      = r_chunk;
        n_sum        = r_sum;
        n_halted     = r_halted;
        fail         = 1'b0;
        o_push       = 1'b0;
        o_cmd        = '0;
        if (work) begin
            unique case (r_phase)
                PhType: begin
                    if (i_in_byte < 8'd2 || i_in_byte >= TypeLimit || i_in_byte[0]) begin
                        fail = 1'b1;
                    end else begin
                        n_kind  = (i_in_byte == TypeContent) ? KindContent :
                                  (i_in_byte == TypeEnd) ? KindEnd : KindSkip;
                        n_phase = PhLenLo;
                    end
                end
                PhLenLo: begin
                    n_bytes_left = {8'h00, i_in_byte};
                    n_phase      = PhLenHi;
                end
                PhLenHi: begin
                    n_bytes_left = full_len;
                    if (r_kind == KindEnd) begin
                        n_phase = PhEndA;
                    end else if (r_kind == KindContent) begin
                        if (full_len < 16'd4) begin
                            fail = 1'b1;
                        end else begin
                            n_bytes_left = full_len - 16'd4;
                            n_chunk      = 8'd0;
                            n_phase      = PhSeg;
                        end
                    end else begin
                        n_phase = (full_len == 16'd0) ? PhType : PhSkip;
                    end
                end
                PhSkip: begin
                    n_bytes_left = r_bytes_left - 16'd1;
                    if (r_bytes_left == 16'd1) begin
                        n_phase = PhType;
                    end
                end
                PhEndA: n_phase = PhEndB;
                PhEndB: n_phase = PhEndLo;
                PhEndLo: begin
                    n_addr  = {8'h00, i_in_byte};
                    n_phase = PhEndHi;
                end
                PhEndHi: begin
                    n_addr         = {i_in_byte, r_addr[7:0]};
                    n_halted       = 1'b1;
                    o_push         = 1'b1;
                    o_cmd.is_done  = 1'b1;
                    o_cmd.has_hdr  = 1'b1;
                    o_cmd.has_tail = 1'b1;
                    o_cmd.rtype    = 1'b1;
                    o_cmd.addr_hi  = i_in_byte;
                    o_cmd.addr_lo  = r_addr[7:0];
                    o_cmd.csum     = 8'd0 - end_sum;
                end
                PhSeg: n_phase = PhAddrLo;
                PhAddrLo: begin
                    n_addr  = {8'h00, i_in_byte};
                    n_phase = PhAddrHi;
                end
                PhAddrHi: begin
                    n_addr  = {i_in_byte, r_addr[7:0]};
                    n_phase = (r_bytes_left == 16'd0) ? PhCrc : PhData;
                end
                PhData: begin
                    n_sum          = new_sum;
                    n_chunk        = new_chunk;
                    n_bytes_left   = r_bytes_left - 16'd1;
                    n_addr         = r_addr + 16'd1;
                    o_push         = 1'b1;
                    o_cmd.has_hdr  = chunk_open;
                    o_cmd.has_data = 1'b1;
                    o_cmd.has_tail = (new_chunk == 8'd0);
                    o_cmd.len      = len;
                    o_cmd.addr_hi  = r_addr[15:8];
                    o_cmd.addr_lo  = r_addr[7:0];
                    o_cmd.data     = i_in_byte;
                    o_cmd.csum     = 8'd0 - new_sum;
                    if (r_bytes_left == 16'd1) begin
                        n_phase = PhCrc;
                    end
                end
                PhCrc: n_phase = PhType;
                default: n_phase = PhType;
            endcase
            // bad type or short content record
            if (fail) begin
                n_halted     = 1'b1;
                o_push       = 1'b1;
                o_cmd        = '0;
                o_cmd.is_err = 1'b1;
            end
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PhType;
            r_kind       <= KindSkip;
            r_bytes_left <= '0;
            r_addr       <= '0;
            r_chunk      <= '0;
            r_sum        <= '0;
            r_halted     <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_kind       <= n_kind;
            r_bytes_left <= n_bytes_left;
            r_addr       <= n_addr;
            r_chunk      <= n_chunk;
            r_sum        <= n_sum;
            r_halted     <= n_halted;
        end
    end

    // once halted the parser never issues another command
    a_halt_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> !o_push)
        else $error("command issued after halt");

    // a command is only issued when the queue has room
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_full)
        else $error("command issued into full queue");

    // an error command ends the conversion
    a_err_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_cmd.is_err) |=> r_halted)
        else $error("error did not halt parser");

endmodule

### design/ohc_queue.sv
// short command queue between parser and text sequencer
`timescale 1ns / 1ps

module ohc_queue
    import ohc_pkg::*;
#(
    parameter int DEPTH = QueueDepth
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_head
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

    t_cmd            r_mem [DEPTH];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;

    assign o_full  = (r_count == CntFull);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrLast) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrLast) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("queue underflow");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntFull)
        else $error("queue count out of range");

endmodule

### design/ohc_back.sv
// text sequencer: spells each command out as hex text, one character per cycle while a command waits and i_stall is low
`timescale 1ns / 1ps

module ohc_back
    import ohc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_cmd       i_head,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_char,
    output logic       o_last_of_run,
    output logic       o_error_flag,
    output logic       o_module_done
);

    // character positions within one hex record
    localparam logic [3:0] StColon  = 4'd0;
    localparam logic [3:0] StLenHi  = 4'd1;
    localparam logic [3:0] StLenLo  = 4'd2;
    localparam logic [3:0] StAhiHi  = 4'd3;
    localparam logic [3:0] StAhiLo  = 4'd4;
    localparam logic [3:0] StAloHi  = 4'd5;
    localparam logic [3:0] StAloLo  = 4'd6;
    localparam logic [3:0] StTypHi  = 4'd7;
    localparam logic [3:0] StTypLo  = 4'd8;
    localparam logic [3:0] StDatHi  = 4'd9;
    localparam logic [3:0] StDatLo  = 4'd10;
    localparam logic [3:0] StSumHi  = 4'd11;
    localparam logic [3:0] StSumLo  = 4'd12;
    localparam logic [3:0] StNl     = 4'd13;

    logic       r_mid;
    logic [3:0] r_step;
    logic       r_valid;
    logic [7:0] r_char;
    logic       r_last;
    logic       r_err;
    logic       r_done;

    logic       emit;
    logic [3:0] cur;
    logic [3:0] nxt;
    logic       last;
    logic [7:0] ch;

    // a new character enters the output register when it is free or taken
    assign emit = !i_empty && (!r_valid || !i_stall);
    assign cur  = r_mid ? r_step : (i_head.has_hdr ? StColon : StDatHi);
    assign nxt  = (cur == StTypLo && !i_head.has_data) ? StSumHi : cur + 4'd1;
    assign last = i_head.is_err || cur == StNl || (cur == StDatLo && !i_head.has_tail);
    assign o_pop = emit && last;

    // character select
    always_comb begin
        unique case (cur)
            StColon: ch = CharColon;
            StLenHi: ch = hex_char(i_head.len[7:4]);
            StLenLo: ch = hex_char(i_head.len[3:0]);
            StAhiHi: ch = hex_char(i_head.addr_hi[7:4]);
            StAhiLo: ch = hex_char(i_head.addr_hi[3:0]);
            StAloHi: ch = hex_char(i_head.addr_lo[7:4]);
            StAloLo: ch = hex_char(i_head.addr_lo[3:0]);
            StTypHi: ch = CharZero;
            StTypLo: ch = hex_char({3'b000, i_head.rtype});
            StDatHi: ch = hex_char(i_head.data[7:4]);
            StDatLo: ch = hex_char(i_head.data[3:0]);
            StSumHi: ch = hex_char(i_head.csum[7:4]);
            StSumLo: ch = hex_char(i_head.csum[3:0]);
            StNl:    ch = CharNewline;
            default: ch = CharError;
        endcase
        if (i_head.is_err) begin
            ch = CharError;
        end
    end

    // position within the current command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid  <= 1'b0;
            r_step <= StColon;
        end else if (emit) begin
            r_mid  <= !last;
            r_step <= nxt;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (emit) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_char <= ch;
            r_last <= last;
            r_err  <= i_head.is_err;
            r_done <= i_head.is_done;
        end
    end

    assign o_valid       = r_valid;
    assign o_out_char    = r_char;
    assign o_last_of_run = r_last;
    assign o_error_flag  = r_err;
    assign o_module_done = r_done;

    // the error item stands alone
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_err) |-> (r_last && !r_done))
        else $error("error item not a single run");

    // a command is only released on its final character
    a_pop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_valid && r_last))
        else $error("command released early");

    // the sequencer never stays mid-command past a newline
    a_nl_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && cur == StNl) |=> !r_mid)
        else $error("newline did not close command");

endmodule

### design/object_record_to_hex_converter.sv
// top level of the object record to hex text converter
`timescale 1ns / 1ps
//
// Usage: object file bytes enter on i_valid / o_stall / i_in_byte, one byte per item.
// Hex text leaves on o_valid / i_stall, one ASCII character per item on o_out_char,
// with o_last_of_run marking the final character caused by an input byte,
// o_error_flag on the single error item and o_module_done on the end record text.
// i_cfg_wr_en with i_cfg_wr_data sets the largest data byte count per hex record
// (reset 16); write it only while the block is idle.
// A byte that makes text passes the command queue and then the output register
// before its first character shows. The output gives one character per cycle while
// i_stall is low and the queue holds a command; a data byte costs 2 characters, plus
// 9 header and 3 trailer characters per hex record, so about 2.75 characters per
// data byte at 16-byte records. The parser takes one byte per cycle as long as the
// command queue (QUEUE_DEPTH entries) has room; o_stall is the queue-full flag.
// Reset clears the parser, the queue and the output register; the record size
// register returns to 16. When the receiver stalls, the held character stays,
// the queue fills and then o_stall rises. After an end record or an error the
// block takes and drops every further byte until reset.
//
module object_record_to_hex_converter
    import ohc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepth
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_char,
    output logic       o_last_of_run,
    output logic       o_error_flag,
    output logic       o_module_done
);

    logic [7:0] r_max_rec;
    logic       push;
    logic       pop;
    logic       full;
    logic       empty;
    t_cmd       cmd_in;
    t_cmd       head;

    // record size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_rec <= MaxRecordReset;
        end else if (i_cfg_wr_en) begin
            r_max_rec <= i_cfg_wr_data;
        end
    end

    // parser
    ohc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_in_byte (i_in_byte),
        .o_stall   (o_stall),
        .i_max_rec (r_max_rec),
        .i_full    (full),
        .o_push    (push),
        .o_cmd     (cmd_in)
    );

    // command queue
    ohc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_head  (head)
    );

    // text sequencer
    ohc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (empty),
        .i_head        (head),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_char    (o_out_char),
        .o_last_of_run (o_last_of_run),
        .o_error_flag  (o_error_flag),
        .o_module_done (o_module_done)
    );

endmodule
